// ===== src/edt_pkg.sv =====
// types, constants and helper functions shared by the tokenizer modules
// no dependencies
`default_nettype none

package edt_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_OPEN      = 8'h5b;
   localparam logic [7:0] CHAR_CLOSE     = 8'h5d;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CODE_LF        = 8'h0a;
   localparam logic [7:0] CODE_TAB       = 8'h09;
   localparam logic [7:0] CODE_VT        = 8'h0b;
   localparam logic [7:0] CODE_BS        = 8'h08;
   localparam logic [7:0] CODE_CR        = 8'h0d;
   localparam logic [7:0] CODE_FF        = 8'h0c;
   localparam logic [7:0] CODE_BEL       = 8'h07;
   localparam logic [7:0] CHAR_N         = 8'h6e;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_V         = 8'h76;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_A         = 8'h61;

   // output beats of one hex form: [ 0 x h h ]
   localparam int HEX_BEATS = 6;
   localparam logic [2:0] STEP_OPEN  = 3'd0;
   localparam logic [2:0] STEP_ZERO  = 3'd1;
   localparam logic [2:0] STEP_X     = 3'd2;
   localparam logic [2:0] STEP_HIGH  = 3'd3;
   localparam logic [2:0] STEP_LOW   = 3'd4;
   localparam logic [2:0] STEP_CLOSE = 3'd5;

   localparam int MAP_REGS = 4;
   localparam int MAP_BITS = 64;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       token_last;
   } rsp_type;

   // one or two token bytes from one input beat; the second always ends a token
   typedef struct packed {
      logic [7:0] byte0;
      logic       last0;
      logic       has1;
      logic [7:0] byte1;
   } tok_entry_type;

   function automatic logic needs_hex(input logic [7:0] c);
      needs_hex = (c == CODE_LF) || (c == CODE_TAB) || (c == CODE_VT) ||
                  (c == CODE_BS) || (c == CODE_CR) || (c == CODE_FF) ||
                  (c == CODE_BEL) || (c == CHAR_BACKSLASH) || (c == CHAR_QUOTE);
   endfunction

   function automatic logic [7:0] decode_escape(input logic [7:0] c);
      case (c)
         CHAR_N:  decode_escape = CODE_LF;
         CHAR_T:  decode_escape = CODE_TAB;
         CHAR_V:  decode_escape = CODE_VT;
         CHAR_B:  decode_escape = CODE_BS;
         CHAR_R:  decode_escape = CODE_CR;
         CHAR_F:  decode_escape = CODE_FF;
         CHAR_A:  decode_escape = CODE_BEL;
         default: decode_escape = c;
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         hex_char = 8'h30 + {4'd0, nib};
      end else begin
         hex_char = 8'h57 + {4'd0, nib};
      end
   endfunction

endpackage

`default_nettype wire

// ===== src/escaped_delimiter_tokenizer.sv =====
// top level of the escaped delimiter tokenizer: register file and module wiring
// depends on edt_pkg, edt_front, edt_fifo, edt_back
`default_nettype none

// Takes one raw byte per beat on req_ (in_last marks the end of a string) and
// returns token bytes on rsp_, with token_last on the final beat of each token.
// The front decodes escapes, looks up the 256-bit delimiter map combinationally
// and accepts a byte every cycle while the token queue (QUEUE_DEPTH entries) has
// room. The back sends one beat per cycle: a plain token byte is one beat, a
// control code, backslash or quote is six beats ("[0xhh]"), so throughput is
// one input byte per cycle until hex forms or rsp_ready stalls fill the queue.
// The four 64-bit map registers sit at byte addresses 0, 8, 16 and 24, reset to
// zero; users write only while the block is idle, unenforced. No clearing pass.
module escaped_delimiter_tokenizer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire edt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output edt_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [4:0]       paddr,
   input  wire logic [63:0]      pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);
   import edt_pkg::*;

   logic [MAP_BITS-1:0] delim_map_ff [MAP_REGS];
   logic [MAP_BITS-1:0] delim_map_in;
   logic                csr_write;
   logic [1:0]          csr_index;
   logic [255:0]        delim_flat;

   logic          q_push, q_pop, q_full, q_not_empty;
   tok_entry_type q_entry, q_head;

   assign pready       = 1'b1;
   assign csr_index    = paddr[4:3];
   assign csr_write    = psel && penable && pwrite && pready;
   assign delim_map_in = pwdata;
   assign prdata       = delim_map_ff[csr_index];
   assign delim_flat   = {delim_map_ff[3], delim_map_ff[2], delim_map_ff[1], delim_map_ff[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_REGS; i++) begin
            delim_map_ff[i] <= '0;
         end
      end else if (csr_write) begin
         delim_map_ff[csr_index] <= delim_map_in;
      end
   end

   edt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .delim_map (delim_flat),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   edt_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   edt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/edt_front.sv =====
// front end: escape decoding, delimiter lookup and the held token byte
// depends on edt_pkg
`default_nettype none

module edt_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire edt_pkg::req_type       req_data,
   input  wire logic [255:0]           delim_map,
   input  wire logic                   q_full,
   output logic                        q_push,
   output edt_pkg::tok_entry_type      q_entry
);
   import edt_pkg::*;

   logic       escape_pending_ff, escape_pending_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_byte_ff, held_byte_in;

   logic       accept;
   logic       have;
   logic [7:0] c;
   logic       is_delim;
   logic       first_valid, first_last;
   logic       mid_valid;
   logic [7:0] mid_byte;
   logic       end_valid;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      have = 1'b0;
      c    = req_data.in_byte;
      escape_pending_in = 1'b0;
      if (escape_pending_ff) begin
         have = 1'b1;
         c    = decode_escape(req_data.in_byte);
      end else if (req_data.in_byte == CHAR_BACKSLASH) begin
         escape_pending_in = !req_data.in_last;
      end else begin
         have = 1'b1;
      end
      is_delim = delim_map[c];

      first_valid = 1'b0;
      first_last  = 1'b0;
      mid_valid   = held_valid_ff;
      mid_byte    = held_byte_ff;
      if (have) begin
         if (is_delim) begin
            first_valid = held_valid_ff;
            first_last  = 1'b1;
            mid_valid   = 1'b0;
         end else begin
            first_valid = held_valid_ff;
            first_last  = 1'b0;
            mid_valid   = 1'b1;
            mid_byte    = c;
         end
      end
      end_valid = req_data.in_last && mid_valid;

      if (req_data.in_last) begin
         escape_pending_in = 1'b0;
      end
      held_valid_in = mid_valid && !req_data.in_last;
      held_byte_in  = mid_byte;

      if (first_valid) begin
         q_entry.byte0 = held_byte_ff;
         q_entry.last0 = first_last;
         q_entry.has1  = end_valid;
      end else begin
         q_entry.byte0 = mid_byte;
         q_entry.last0 = 1'b1;
         q_entry.has1  = 1'b0;
      end
      q_entry.byte1 = mid_byte;
      q_push = accept && (first_valid || end_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
         held_valid_ff     <= 1'b0;
      end else if (accept) begin
         escape_pending_ff <= escape_pending_in;
         held_valid_ff     <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_byte_ff <= held_byte_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/edt_fifo.sv =====
// short queue of token entries between front and back
// depends on edt_pkg
`default_nettype none

module edt_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire edt_pkg::tok_entry_type push_entry,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        not_empty,
   output edt_pkg::tok_entry_type      head
);
   import edt_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tok_entry_type store_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== src/edt_back.sv =====
// back end: expands queued token bytes into output beats, with hex forms
// depends on edt_pkg
`default_nettype none

module edt_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_not_empty,
   input  wire edt_pkg::tok_entry_type q_head,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output edt_pkg::rsp_type            rsp_data
);
   import edt_pkg::*;

   logic          work_valid_ff, work_valid_in;
   tok_entry_type work_ff, work_in;
   logic          sel_ff, sel_in;
   logic [2:0]    step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic       out_load;
   logic       fire;
   logic       byte_done;
   logic       work_done;
   logic [7:0] cur_byte;
   logic       cur_last;
   logic       cur_hex;
   rsp_type    beat;

   always_comb begin
      cur_byte = sel_ff ? work_ff.byte1 : work_ff.byte0;
      cur_last = sel_ff ? 1'b1 : work_ff.last0;
      cur_hex  = needs_hex(cur_byte);

      beat.token_last = cur_last;
      beat.out_byte   = cur_byte;
      if (cur_hex) begin
         beat.token_last = cur_last && (step_ff == STEP_CLOSE);
         case (step_ff)
            STEP_OPEN:  beat.out_byte = CHAR_OPEN;
            STEP_ZERO:  beat.out_byte = CHAR_ZERO;
            STEP_X:     beat.out_byte = CHAR_X;
            STEP_HIGH:  beat.out_byte = hex_char(cur_byte[7:4]);
            STEP_LOW:   beat.out_byte = hex_char(cur_byte[3:0]);
            default:    beat.out_byte = CHAR_CLOSE;
         endcase
      end

      out_load  = !rsp_valid_ff || rsp_ready;
      fire      = work_valid_ff && out_load;
      byte_done = fire && (!cur_hex || step_ff == STEP_CLOSE);
      work_done = byte_done && (sel_ff || !work_ff.has1);
      q_pop     = q_not_empty && (!work_valid_ff || work_done);

      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      sel_in        = sel_ff;
      step_in       = step_ff;
      if (q_pop) begin
         work_valid_in = 1'b1;
         work_in       = q_head;
         sel_in        = 1'b0;
         step_in       = STEP_OPEN;
      end else if (work_done) begin
         work_valid_in = 1'b0;
      end else if (byte_done) begin
         sel_in  = 1'b1;
         step_in = STEP_OPEN;
      end else if (fire) begin
         step_in = step_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = work_valid_ff;
         rsp_data_in  = beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         sel_ff        <= 1'b0;
         step_ff       <= STEP_OPEN;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         sel_ff        <= sel_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_CLOSE)
      else $error("hex step out of range");
   a_sel_needs_second: assert property (@(posedge clock) disable iff (reset)
      (work_valid_ff && sel_ff) |-> work_ff.has1)
      else $error("second byte selected but absent");
   a_plain_single_step: assert property (@(posedge clock) disable iff (reset)
      (work_valid_ff && !cur_hex) |-> (step_ff == STEP_OPEN))
      else $error("plain byte advanced past first step");
`endif

endmodule

`default_nettype wire
